// File: sv/sr_arq_pkg.sv
// Shared types, constants and codes for the selective-repeat ARQ sender.
package sr_arq_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int MAX_RESULTS  = 16;
    localparam int RES_W        = $clog2(MAX_RESULTS + 1);
    localparam int SEQ_W        = 16;
    localparam int WLIMIT_W     = 5;
    localparam int CFG_IDX_W    = 1;

    typedef logic [SEQ_W-1:0] t_word;

    localparam t_word                DEPTH_WORD    = t_word'(WINDOW_DEPTH);
    localparam t_word                TIMEOUT_RESET = t_word'(100);
    localparam logic [WLIMIT_W-1:0]  WLIMIT_RESET  = WLIMIT_W'(10);
    localparam logic [RES_W-1:0]     RES_LIMIT     = RES_W'(MAX_RESULTS);
    localparam t_word                ACK_CODE_ACK  = t_word'(1);
    localparam t_word                ACK_CODE_NAK  = t_word'(2);

    typedef enum logic [1:0] {
        OP_SUBMIT = 2'd0,
        OP_ACK    = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        EV_SENT    = 4'd0,
        EV_FULL    = 4'd1,
        EV_ACKED   = 4'd2,
        EV_DUP     = 4'd3,
        EV_OUTSIDE = 4'd4,
        EV_NAK     = 4'd5,
        EV_CORRUPT = 4'd6,
        EV_TIMEOUT = 4'd7,
        EV_IDLE    = 4'd8
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT = 1'b0,
        REG_WLIMIT  = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ALU_SUB  = 2'd0,
        ALU_ADD  = 2'd1,
        ALU_ADDC = 2'd2
    } t_alu_op;

    typedef struct packed {
        t_alu_op op;
        t_word   a;
        t_word   b;
        t_word   c;
    } t_alu_req;

    typedef struct packed {
        t_word res;
        logic  lt;
        logic  zero;
    } t_alu_rsp;

    typedef struct packed {
        logic  acked_en;
        logic  acked_val;
        logic  stamp_en;
        t_word stamp_val;
    } t_slot_wr;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NOP,
        S_SUB_ROOM,
        S_SUB_INC,
        S_CK_ADD1,
        S_CK_ADD2,
        S_ACK_OUTS,
        S_ACK_WIN,
        S_SLIDE_CMP,
        S_SLIDE_INC,
        S_TICK_NOW,
        S_TICK_CNT,
        S_SCAN_AGE,
        S_SCAN_INC
    } t_state;

endpackage

// File: sv/sr_arq_if.sv
// Valid/ready channel interfaces: input items, result items, register writes.
interface sr_arq_in_if;
    import sr_arq_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    t_word       ack_seq;
    t_word       ack_code;
    t_word       ack_length;
    t_word       ack_checksum;
    modport source (output valid, opcode, ack_seq, ack_code, ack_length, ack_checksum,
                    input ready);
    modport sink   (input valid, opcode, ack_seq, ack_code, ack_length, ack_checksum,
                    output ready);
endinterface

interface sr_arq_out_if;
    import sr_arq_pkg::*;
    logic        valid;
    logic        ready;
    logic [3:0]  event_kind;
    t_word       packet_seq;
    t_word       window_base;
    t_word       next_seq;
    logic        last;
    modport source (output valid, event_kind, packet_seq, window_base, next_seq, last,
                    input ready);
    modport sink   (input valid, event_kind, packet_seq, window_base, next_seq, last,
                    output ready);
endinterface

interface sr_arq_cfg_if;
    import sr_arq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_word                data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/sr_arq_alu.sv
// Shared 16-bit arithmetic unit: subtract with compare, add, end-around-carry add.
module sr_arq_alu (
    input  sr_arq_pkg::t_alu_req i_req,
    output sr_arq_pkg::t_alu_rsp o_rsp
);
    import sr_arq_pkg::*;

    logic [SEQ_W:0] sum;
    t_word          diff;

    always_comb begin
        sum  = {1'b0, i_req.a} + {1'b0, i_req.b};
        diff = i_req.a - i_req.b;
        case (i_req.op)
            ALU_SUB:  o_rsp.res = diff;
            ALU_ADD:  o_rsp.res = sum[SEQ_W-1:0];
            // fold the carry back in; cannot overflow a second time
            ALU_ADDC: o_rsp.res = sum[SEQ_W-1:0] + t_word'(sum[SEQ_W]);
            default:  o_rsp.res = diff;
        endcase
        o_rsp.lt   = (diff < i_req.c);
        o_rsp.zero = (diff == '0);
    end
endmodule

// File: sv/sr_arq_slots.sv
// Per-slot state of the send window: acked flags and send time stamps.
module sr_arq_slots (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [sr_arq_pkg::SLOT_W-1:0]  i_addr,
    input  sr_arq_pkg::t_slot_wr           i_wr,
    output logic                           o_acked,
    output sr_arq_pkg::t_word              o_stamp
);
    import sr_arq_pkg::*;

    logic [WINDOW_DEPTH-1:0] r_acked;
    t_word                   r_stamp [WINDOW_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acked <= '0;
        end else if (i_wr.acked_en) begin
            r_acked[i_addr] <= i_wr.acked_val;
        end
    end

    // stamps are always written when a slot enters the window
    always_ff @(posedge i_clk) begin
        if (i_wr.stamp_en) begin
            r_stamp[i_addr] <= i_wr.stamp_val;
        end
    end

    assign o_acked = r_acked[i_addr];
    assign o_stamp = r_stamp[i_addr];
endmodule

// File: sv/selective_repeat_arq_sender.sv
// Selective-repeat ARQ sender bookkeeping: window, ack check and timeout scan.
//
// Each input beat is a submit, an ack header or a one-millisecond tick, and
// yields one or more result beats, the final one flagged by last. All work
// runs on one shared 16-bit add/subtract/compare unit under a small
// sequencer, one operation per clock while no result is held back, so one
// item is in flight at a time and the input is ready only while the
// sequencer is idle. A submit claims the tail slot or reports the window
// full; a reserved opcode gives one idle result; an ack header ends after
// the checksum when corrupt or of an unknown code, after the window check
// when outside, a nak or a duplicate, and a new ack then slides the base
// past the acked slots; a tick scans each outstanding packet (at most the
// window depth of 16). A result beat waiting in the output register stalls
// the sequencer only when the next result is ready to go out. Register
// writes are taken in any cycle and must only come while the block is idle.
module selective_repeat_arq_sender (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sr_arq_in_if.sink     i_item,
    sr_arq_out_if.source  o_result,
    sr_arq_cfg_if.sink    i_cfg
);
    import sr_arq_pkg::*;

    // control state
    t_state                r_state, n_state;
    t_word                 r_base, n_base;
    t_word                 r_tail, n_tail;
    t_word                 r_now, n_now;
    t_word                 r_timeout;
    logic [WLIMIT_W-1:0]   r_wlimit;
    logic                  r_out_valid;
    logic [CNT_W-1:0]      r_i, n_i;
    logic [RES_W-1:0]      r_n, n_n;
    logic                  r_pend_v, n_pend_v;

    // datapath
    t_word                 r_ack_seq, r_ack_code, r_ack_len, r_ack_chk;
    t_word                 r_acc, n_acc;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    t_word                 r_scan_seq, n_scan_seq;
    t_word                 r_pend_seq, n_pend_seq;

    // output register
    t_event                r_out_kind;
    t_word                 r_out_seq, r_out_base, r_out_next;
    logic                  r_out_last;

    // sequencer outputs
    t_alu_req              alu_req;
    t_alu_rsp              alu_rsp;
    logic [SLOT_W-1:0]     slot_addr;
    t_slot_wr              slot_wr;
    logic                  slot_acked;
    t_word                 slot_stamp;
    logic                  em_req;
    t_event                em_kind;
    t_word                 em_seq, em_next;
    logic                  em_last;
    logic                  out_free, go, out_load, in_fire;
    t_word                 lim;
    t_word                 outst;

    sr_arq_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    sr_arq_slots u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (slot_addr),
        .i_wr    (slot_wr),
        .o_acked (slot_acked),
        .o_stamp (slot_stamp)
    );

    assign i_item.ready = (r_state == S_IDLE);
    assign in_fire      = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;
    assign out_free     = !r_out_valid || o_result.ready;

    // effective window: the smaller of the register and the depth
    assign lim   = (t_word'(r_wlimit) < DEPTH_WORD) ? t_word'(r_wlimit) : DEPTH_WORD;
    assign outst = r_tail - r_base;

    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_tail     = r_tail;
        n_now      = r_now;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_scan_seq = r_scan_seq;
        n_i        = r_i;
        n_n        = r_n;
        n_pend_v   = r_pend_v;
        n_pend_seq = r_pend_seq;
        alu_req    = '{op: ALU_SUB, a: r_tail, b: r_base, c: '0};
        slot_addr  = r_ack_seq[SLOT_W-1:0];
        slot_wr    = '0;
        em_req     = 1'b0;
        em_kind    = EV_IDLE;
        em_seq     = '0;
        em_next    = r_tail;
        em_last    = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (t_opcode'(i_item.opcode))
                        OP_SUBMIT: n_state = S_SUB_ROOM;
                        OP_ACK:    n_state = S_CK_ADD1;
                        OP_TICK:   n_state = S_TICK_NOW;
                        default:   n_state = S_NOP;
                    endcase
                end
            end
            S_NOP: begin
                em_req  = 1'b1;
                n_state = S_IDLE;
            end
            S_SUB_ROOM: begin
                alu_req   = '{op: ALU_SUB, a: r_tail, b: r_base, c: lim};
                slot_addr = r_tail[SLOT_W-1:0];
                if (alu_rsp.lt) begin
                    // claim the slot: clear its flag and stamp the send time
                    slot_wr = '{acked_en: 1'b1, acked_val: 1'b0,
                                stamp_en: 1'b1, stamp_val: r_now};
                    n_state = S_SUB_INC;
                end else begin
                    em_req  = 1'b1;
                    em_kind = EV_FULL;
                    em_seq  = r_tail;
                    n_state = S_IDLE;
                end
            end
            S_SUB_INC: begin
                alu_req = '{op: ALU_ADD, a: r_tail, b: t_word'(1), c: '0};
                em_req  = 1'b1;
                em_kind = EV_SENT;
                em_seq  = r_tail;
                em_next = alu_rsp.res;
                n_tail  = alu_rsp.res;
                n_state = S_IDLE;
            end
            S_CK_ADD1: begin
                alu_req = '{op: ALU_ADDC, a: r_ack_seq, b: r_ack_code, c: '0};
                n_acc   = alu_rsp.res;
                n_state = S_CK_ADD2;
            end
            S_CK_ADD2: begin
                alu_req = '{op: ALU_ADDC, a: r_acc, b: r_ack_len, c: '0};
                if (~alu_rsp.res != r_ack_chk) begin
                    em_req  = 1'b1;
                    em_kind = EV_CORRUPT;
                    em_seq  = r_ack_seq;
                    n_state = S_IDLE;
                end else if (r_ack_code == ACK_CODE_ACK || r_ack_code == ACK_CODE_NAK) begin
                    n_state = S_ACK_OUTS;
                end else begin
                    em_req  = 1'b1;
                    em_kind = EV_IDLE;
                    em_seq  = r_ack_seq;
                    n_state = S_IDLE;
                end
            end
            S_ACK_OUTS: begin
                n_cnt   = alu_rsp.res[CNT_W-1:0];
                n_state = S_ACK_WIN;
            end
            S_ACK_WIN: begin
                alu_req = '{op: ALU_SUB, a: r_ack_seq, b: r_base, c: t_word'(r_cnt)};
                em_seq  = r_ack_seq;
                n_state = S_IDLE;
                if (!alu_rsp.lt) begin
                    em_req  = 1'b1;
                    em_kind = EV_OUTSIDE;
                end else if (r_ack_code == ACK_CODE_NAK) begin
                    slot_wr.stamp_en  = 1'b1;
                    slot_wr.stamp_val = r_now;
                    em_req            = 1'b1;
                    em_kind           = EV_NAK;
                end else if (slot_acked) begin
                    em_req  = 1'b1;
                    em_kind = EV_DUP;
                end else begin
                    slot_wr.acked_en  = 1'b1;
                    slot_wr.acked_val = 1'b1;
                    n_state           = S_SLIDE_CMP;
                end
            end
            S_SLIDE_CMP: begin
                slot_addr = r_base[SLOT_W-1:0];
                if (alu_rsp.zero || !slot_acked) begin
                    em_req  = 1'b1;
                    em_kind = EV_ACKED;
                    em_seq  = r_ack_seq;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SLIDE_INC;
                end
            end
            S_SLIDE_INC: begin
                alu_req = '{op: ALU_ADD, a: r_base, b: t_word'(1), c: '0};
                n_base  = alu_rsp.res;
                n_state = S_SLIDE_CMP;
            end
            S_TICK_NOW: begin
                alu_req = '{op: ALU_ADD, a: r_now, b: t_word'(1), c: '0};
                n_now   = alu_rsp.res;
                n_state = S_TICK_CNT;
            end
            S_TICK_CNT: begin
                n_cnt      = alu_rsp.res[CNT_W-1:0];
                n_scan_seq = r_base;
                n_i        = '0;
                n_n        = '0;
                n_pend_v   = 1'b0;
                n_state    = S_SCAN_AGE;
            end
            S_SCAN_AGE: begin
                // age of the slot against the timeout; a hit is held back until the
                // next hit or the end of the scan so the final one can carry last
                alu_req   = '{op: ALU_SUB, a: r_now, b: slot_stamp, c: r_timeout};
                slot_addr = r_scan_seq[SLOT_W-1:0];
                if (r_i == r_cnt || r_n == RES_LIMIT) begin
                    em_req  = 1'b1;
                    em_kind = r_pend_v ? EV_TIMEOUT : EV_IDLE;
                    em_seq  = r_pend_v ? r_pend_seq : '0;
                    n_state = S_IDLE;
                end else if (!slot_acked && !alu_rsp.lt) begin
                    slot_wr.stamp_en  = 1'b1;
                    slot_wr.stamp_val = r_now;
                    n_pend_v          = 1'b1;
                    n_pend_seq        = r_scan_seq;
                    n_n               = r_n + 1'b1;
                    if (r_pend_v) begin
                        em_req  = 1'b1;
                        em_kind = EV_TIMEOUT;
                        em_seq  = r_pend_seq;
                        em_last = 1'b0;
                    end
                    n_state = S_SCAN_INC;
                end else begin
                    n_state = S_SCAN_INC;
                end
            end
            S_SCAN_INC: begin
                alu_req    = '{op: ALU_ADD, a: r_scan_seq, b: t_word'(1), c: '0};
                n_scan_seq = alu_rsp.res;
                n_i        = r_i + 1'b1;
                n_state    = S_SCAN_AGE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hold the whole step while a result cannot go out
        go = !em_req || out_free;
        if (!go) begin
            slot_wr = '0;
        end
    end

    assign out_load = em_req && go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_tail      <= '0;
            r_now       <= '0;
            r_timeout   <= TIMEOUT_RESET;
            r_wlimit    <= WLIMIT_RESET;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_n         <= '0;
            r_pend_v    <= 1'b0;
        end else begin
            if (go) begin
                r_state  <= n_state;
                r_base   <= n_base;
                r_tail   <= n_tail;
                r_now    <= n_now;
                r_i      <= n_i;
                r_n      <= n_n;
                r_pend_v <= n_pend_v;
            end
            if (i_cfg.valid) begin
                case (t_cfg_reg'(i_cfg.index))
                    REG_TIMEOUT: r_timeout <= i_cfg.data;
                    REG_WLIMIT:  r_wlimit  <= i_cfg.data[WLIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ack_seq  <= i_item.ack_seq;
            r_ack_code <= i_item.ack_code;
            r_ack_len  <= i_item.ack_length;
            r_ack_chk  <= i_item.ack_checksum;
        end
        if (go) begin
            r_acc      <= n_acc;
            r_cnt      <= n_cnt;
            r_scan_seq <= n_scan_seq;
            r_pend_seq <= n_pend_seq;
        end
        if (out_load) begin
            r_out_kind <= em_kind;
            r_out_seq  <= em_seq;
            r_out_base <= n_base;
            r_out_next <= em_next;
            r_out_last <= em_last;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.event_kind  = r_out_kind;
    assign o_result.packet_seq  = r_out_seq;
    assign o_result.window_base = r_out_base;
    assign o_result.next_seq    = r_out_next;
    assign o_result.last        = r_out_last;

    // a new result never overwrites one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || o_result.ready))
        else $error("result register overwritten");

    // outstanding packets never exceed the window depth
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        outst <= DEPTH_WORD)
        else $error("window overrun");

    // the base only slides while packets are outstanding
    a_slide_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLIDE_INC) |-> (r_base != r_tail))
        else $error("base slid past tail");

    // an accepted item always starts the sequencer
    a_item_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("accepted item dropped");
endmodule
